/* rtl/ffpr_pkg.sv */
// ----------------------------------------------------------------------------
// ffpr_pkg
// Shared types, register map and CRC helper for the flag-framed receiver.
// ----------------------------------------------------------------------------
package ffpr_pkg;

    localparam int unsigned CfgAddrW = 4;

    localparam logic [1:0] REG_FLAG_PATTERN  = 2'd0;
    localparam logic [1:0] REG_CRC_INIT      = 2'd1;
    localparam logic [1:0] REG_CRC_FINAL_XOR = 2'd2;

    localparam logic [7:0]  FLAG_RESET = 8'h7E;
    localparam logic [31:0] CRC_RESET  = 32'hFFFF_FFFF;
    localparam logic [31:0] CRC_POLY   = 32'hEDB8_8320;

    localparam logic       KIND_BYTE    = 1'b0;
    localparam logic       KIND_SUMMARY = 1'b1;

    localparam logic [1:0] STATUS_GOOD     = 2'd0;
    localparam logic [1:0] STATUS_BAD_FLAG = 2'd1;
    localparam logic [1:0] STATUS_BAD_CRC  = 2'd2;

    typedef struct packed {
        logic [7:0]  flag_pattern;
        logic [31:0] crc_init;
        logic [31:0] crc_final_xor;
    } cfg_t;

    typedef struct packed {
        logic       item_kind;
        logic [7:0] payload_byte;
        logic [1:0] frame_status;
        logic [3:0] control_code;
        logic [3:0] payload_length;
        logic [7:0] receiver_address;
        logic [7:0] sender_address;
        logic [7:0] sequence_number;
    } result_t;

    // Reflected CRC-32, one byte, LSB first
    function automatic logic [31:0] crc32_byte(input logic [31:0] crc_in,
                                               input logic [7:0]  data);
        logic [31:0] c;
        c = crc_in ^ {24'd0, data};
        for (int k = 0; k < 8; k++) begin
            c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
        end
        return c;
    endfunction

endpackage

/* rtl/ffpr_cfg_regs.sv */
// ----------------------------------------------------------------------------
// ffpr_cfg_regs
// APB register bank: flag pattern, CRC init and CRC final XOR.
// ----------------------------------------------------------------------------
module ffpr_cfg_regs
    import ffpr_pkg::*;
(
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                psel,
    input  logic                penable,
    input  logic                pwrite,
    input  logic [CfgAddrW-1:0] paddr,
    input  logic [31:0]         pwdata,
    output logic [31:0]         prdata,
    output logic                pready,
    output cfg_t                cfg
);

    logic [7:0]  flag_reg;
    logic [31:0] init_reg;
    logic [31:0] fxor_reg;
    logic        wr_en;
    logic [1:0]  reg_idx;

    assign pready  = 1'b1;
    assign wr_en   = psel & penable & pwrite;
    assign reg_idx = paddr[3:2];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            flag_reg <= FLAG_RESET;
            init_reg <= CRC_RESET;
            fxor_reg <= CRC_RESET;
        end else if (wr_en) begin
            if (reg_idx == REG_FLAG_PATTERN)  flag_reg <= pwdata[7:0];
            if (reg_idx == REG_CRC_INIT)      init_reg <= pwdata;
            if (reg_idx == REG_CRC_FINAL_XOR) fxor_reg <= pwdata;
        end
    end

    always_comb begin
        unique case (reg_idx)
            REG_FLAG_PATTERN:  prdata = {24'd0, flag_reg};
            REG_CRC_INIT:      prdata = init_reg;
            REG_CRC_FINAL_XOR: prdata = fxor_reg;
            default:           prdata = 32'd0;
        endcase
    end

    assign cfg = '{flag_pattern: flag_reg, crc_init: init_reg, crc_final_xor: fxor_reg};

endmodule

/* rtl/ffpr_deframer.sv */
// ----------------------------------------------------------------------------
// ffpr_deframer
// Per-bit frame parser: flag hunt, header fields, payload, CRC and close.
// ----------------------------------------------------------------------------
module ffpr_deframer
    import ffpr_pkg::*;
(
    input  logic    aclk,
    input  logic    aresetn,
    input  logic    bit_en,
    input  logic    line_bit,
    input  cfg_t    cfg,
    output logic    res_valid,
    output result_t res
);

    localparam logic [2:0] PH_HUNT   = 3'd0;
    localparam logic [2:0] PH_HEADER = 3'd1;
    localparam logic [2:0] PH_RECV   = 3'd2;
    localparam logic [2:0] PH_SEND   = 3'd3;
    localparam logic [2:0] PH_SEQ    = 3'd4;
    localparam logic [2:0] PH_DATA   = 3'd5;
    localparam logic [2:0] PH_CRC    = 3'd6;
    localparam logic [2:0] PH_CLOSE  = 3'd7;

    logic [2:0]  phase_reg, phase_next;
    logic [7:0]  hunt_reg, hunt_next;
    logic [5:0]  count_reg, count_next;
    logic [31:0] field_reg, field_next;
    logic [3:0]  ctrl_reg, ctrl_next;
    logic [3:0]  len_reg, len_next;
    logic [7:0]  recv_reg, recv_next;
    logic [7:0]  send_reg, send_next;
    logic [7:0]  seq_reg, seq_next;
    logic [3:0]  left_reg, left_next;
    logic [31:0] crc_reg, crc_next;
    logic [31:0] rxcrc_reg, rxcrc_next;

    logic [31:0] shifted;
    logic [5:0]  count_inc;
    logic        field_done8;
    logic [3:0]  left_dec;

    assign shifted     = {field_reg[30:0], line_bit};
    assign count_inc   = count_reg + 6'd1;
    assign field_done8 = (count_inc == 6'd8);
    assign left_dec    = left_reg - 4'd1;

    always_comb begin
        phase_next = phase_reg;
        hunt_next  = hunt_reg;
        count_next = count_reg;
        field_next = field_reg;
        ctrl_next  = ctrl_reg;
        len_next   = len_reg;
        recv_next  = recv_reg;
        send_next  = send_reg;
        seq_next   = seq_reg;
        left_next  = left_reg;
        crc_next   = crc_reg;
        rxcrc_next = rxcrc_reg;
        res_valid  = 1'b0;
        res        = '{item_kind: KIND_BYTE, payload_byte: 8'd0, frame_status: STATUS_GOOD,
                       control_code: ctrl_reg, payload_length: len_reg,
                       receiver_address: recv_reg, sender_address: send_reg,
                       sequence_number: seq_reg};

        if (bit_en) begin
            if (phase_reg == PH_HUNT) begin
                hunt_next = {hunt_reg[6:0], line_bit};
                if (count_reg < 6'd8) count_next = count_inc;
                if ((count_reg >= 6'd7) && (hunt_next == cfg.flag_pattern)) begin
                    phase_next = PH_HEADER;
                    count_next = 6'd0;
                    field_next = 32'd0;
                    crc_next   = cfg.crc_init;
                end
            end else begin
                field_next = shifted;
                count_next = count_inc;
                unique case (phase_reg)
                    PH_HEADER: if (field_done8) begin
                        ctrl_next  = shifted[7:4];
                        len_next   = shifted[3:0];
                        left_next  = shifted[3:0];
                        phase_next = PH_RECV;
                    end
                    PH_RECV: if (field_done8) begin
                        recv_next  = shifted[7:0];
                        phase_next = PH_SEND;
                    end
                    PH_SEND: if (field_done8) begin
                        send_next  = shifted[7:0];
                        phase_next = PH_SEQ;
                    end
                    PH_SEQ: if (field_done8) begin
                        seq_next   = shifted[7:0];
                        phase_next = (left_reg != 4'd0) ? PH_DATA : PH_CRC;
                    end
                    PH_DATA: if (field_done8) begin
                        crc_next         = crc32_byte(crc_reg, shifted[7:0]);
                        res_valid        = 1'b1;
                        res.payload_byte = shifted[7:0];
                        left_next        = left_dec;
                        phase_next       = (left_dec != 4'd0) ? PH_DATA : PH_CRC;
                    end
                    PH_CRC: if (count_inc == 6'd32) begin
                        rxcrc_next = shifted;
                        phase_next = PH_CLOSE;
                    end
                    PH_CLOSE: if (field_done8) begin
                        res_valid     = 1'b1;
                        res.item_kind = KIND_SUMMARY;
                        priority if (shifted[7:0] != cfg.flag_pattern)
                            res.frame_status = STATUS_BAD_FLAG;
                        else if ((crc_reg ^ cfg.crc_final_xor) != rxcrc_reg)
                            res.frame_status = STATUS_BAD_CRC;
                        else
                            res.frame_status = STATUS_GOOD;
                        hunt_next  = 8'd0;
                        phase_next = PH_HUNT;
                    end
                    default: ;
                endcase
                // any field boundary restarts the field counter
                if (phase_next != phase_reg || (phase_reg == PH_DATA && field_done8)) begin
                    count_next = 6'd0;
                    field_next = 32'd0;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg <= PH_HUNT;
            hunt_reg  <= 8'd0;
            count_reg <= 6'd0;
            field_reg <= 32'd0;
            ctrl_reg  <= 4'd0;
            len_reg   <= 4'd0;
            recv_reg  <= 8'd0;
            send_reg  <= 8'd0;
            seq_reg   <= 8'd0;
            left_reg  <= 4'd0;
            crc_reg   <= 32'd0;
            rxcrc_reg <= 32'd0;
        end else begin
            phase_reg <= phase_next;
            hunt_reg  <= hunt_next;
            count_reg <= count_next;
            field_reg <= field_next;
            ctrl_reg  <= ctrl_next;
            len_reg   <= len_next;
            recv_reg  <= recv_next;
            send_reg  <= send_next;
            seq_reg   <= seq_next;
            left_reg  <= left_next;
            crc_reg   <= crc_next;
            rxcrc_reg <= rxcrc_next;
        end
    end

endmodule

/* rtl/ffpr_out_reg.sv */
// ----------------------------------------------------------------------------
// ffpr_out_reg
// Result register on the master side; frees as the beat is taken.
// ----------------------------------------------------------------------------
module ffpr_out_reg
    import ffpr_pkg::*;
(
    input  logic    aclk,
    input  logic    aresetn,
    input  logic    res_valid,
    input  result_t res,
    output logic    can_load,
    output logic    m_tvalid,
    input  logic    m_tready,
    output logic [47:0] m_tdata,  // payload_byte, frame_status, control_code,
                                  // payload_length, receiver_address,
                                  // sender_address, sequence_number, zero fill
    output logic    m_tuser       // item_kind
);

    logic    valid_reg;
    result_t data_reg;

    assign can_load = !valid_reg || m_tready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (can_load) begin
            valid_reg <= res_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (can_load && res_valid) data_reg <= res;
    end

    assign m_tvalid = valid_reg;
    assign m_tuser  = data_reg.item_kind;
    assign m_tdata  = {6'd0, data_reg.sequence_number, data_reg.sender_address,
                       data_reg.receiver_address, data_reg.payload_length,
                       data_reg.control_code, data_reg.frame_status,
                       data_reg.payload_byte};

endmodule

/* rtl/flag_framed_packet_receiver.sv */
// ----------------------------------------------------------------------------
// flag_framed_packet_receiver
// Bit-serial flag-framed deframer with reflected CRC-32 check.
// ----------------------------------------------------------------------------
// One line bit enters per beat and a new bit can be taken on every clock unless
// input is held off; the result (a payload byte or an end-of-frame summary) shows
// in the output register in the cycle after the bit that completes it. The rate
// is set by the per-bit parser, whose CRC byte update is one unrolled XOR network.
// Input is held off only while a result waits and m_tready is low.
// No clearing pass is needed after reset.
module flag_framed_packet_receiver
    import ffpr_pkg::*;
(
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_tvalid,
    output logic                s_tready,
    input  logic [7:0]          s_tdata,   // line_bit, zero fill
    output logic                m_tvalid,
    input  logic                m_tready,
    output logic [47:0]         m_tdata,   // payload_byte, frame_status, control_code,
                                           // payload_length, receiver_address,
                                           // sender_address, sequence_number, zero fill
    output logic                m_tuser,   // item_kind
    input  logic                psel,
    input  logic                penable,
    input  logic                pwrite,
    input  logic [CfgAddrW-1:0] paddr,
    input  logic [31:0]         pwdata,
    output logic [31:0]         prdata,
    output logic                pready
);

    cfg_t    cfg;
    result_t res;
    logic    res_valid;
    logic    can_load;

    assign s_tready = can_load;

    ffpr_cfg_regs u_cfg (
        .aclk    (aclk),
        .aresetn (aresetn),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    ffpr_deframer u_deframer (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .bit_en    (s_tvalid & can_load),
        .line_bit  (s_tdata[0]),
        .cfg       (cfg),
        .res_valid (res_valid),
        .res       (res)
    );

    ffpr_out_reg u_out (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .res_valid (res_valid),
        .res       (res),
        .can_load  (can_load),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser)
    );

endmodule

/* rtl/ffpr_checker.sv */
// ----------------------------------------------------------------------------
// ffpr_checker
// Port-level checks on the receiver's result stream, bound to the top level.
// ----------------------------------------------------------------------------
module ffpr_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_tready,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [47:0] m_tdata,
    input logic        m_tuser
);

    // hold a stalled result beat
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("result beat changed while stalled");

    a_reset_idle: assert property (@(posedge aclk) !aresetn |=> !m_tvalid)
        else $error("result valid straight after reset");

    a_ready_free: assert property (@(posedge aclk) disable iff (!aresetn)
        !m_tvalid |-> s_tready)
        else $error("input held off with empty result register");

    a_byte_status: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tuser |-> m_tdata[9:8] == 2'd0)
        else $error("payload byte beat carries a status");

    a_summary: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser |-> m_tdata[7:0] == 8'd0 && m_tdata[9:8] != 2'd3)
        else $error("malformed summary beat");

endmodule

bind flag_framed_packet_receiver ffpr_checker u_ffpr_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);

/* tb/flag_framed_packet_receiver_check.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// flag_framed_packet_receiver_check
// Watches the line-bit stream, the result stream and the register port of the
// flag-framed receiver. It keeps its own deframer state and register copy,
// queues the result each accepted bit should cause and compares every result
// beat against the oldest entry, field by field.
// ----------------------------------------------------------------------------
module flag_framed_packet_receiver_check
    import ffpr_pkg::*;
(
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_tvalid,
    input  logic                s_tready,
    input  logic [7:0]          s_tdata,      // line_bit, zero fill
    input  logic                m_tvalid,
    input  logic                m_tready,
    input  logic [47:0]         m_tdata,      // payload_byte, frame_status, control_code,
                                              // payload_length, receiver_address,
                                              // sender_address, sequence_number, zero fill
    input  logic                m_tuser,      // item_kind
    input  logic                psel,
    input  logic                penable,
    input  logic                pwrite,
    input  logic [CfgAddrW-1:0] paddr,
    input  logic [31:0]         pwdata,
    input  logic [31:0]         prdata,
    input  logic                pready,
    output int                  mismatches,
    output int                  pending,
    output int                  byte_beats,
    output int                  good_frames,
    output int                  flag_fails,
    output int                  crc_fails
);

    typedef enum logic [2:0] {
        HUNT, HEADER, RECV_ADDR, SEND_ADDR, SEQ_NUM, PAYLOAD, CRC_FIELD, CLOSE_FLAG
    } rx_phase_t;

    cfg_t        regs;
    rx_phase_t   phase_q;
    logic [7:0]  hunt_sr;
    logic [5:0]  bit_cnt;
    logic [31:0] field_sr;
    result_t     frame_hdr;
    logic [3:0]  bytes_to_go;
    logic [31:0] crc_acc;
    logic [31:0] crc_rx;
    logic [31:0] reg_val;
    result_t     results_due[$];
    int          beat_no;

    task automatic report(input string what, input int unsigned got, input int unsigned want);
        $display("[%0t] result %0d: %s is %0h, expected %0h", $time, beat_no, what, got, want);
        mismatches++;
    endtask

    task automatic start_field(input rx_phase_t to_phase);
        phase_q  = to_phase;
        bit_cnt  = 6'd0;
        field_sr = 32'd0;
    endtask

    task automatic deframe_bit(input logic b);
        result_t r;
        logic    done;
        logic    fb;
        int      k;
        r              = frame_hdr;
        r.item_kind    = KIND_BYTE;
        r.payload_byte = 8'd0;
        r.frame_status = STATUS_GOOD;
        if (phase_q == HUNT) begin
            hunt_sr = {hunt_sr[6:0], b};
            if (bit_cnt < 6'd8) bit_cnt++;
            // a flag only counts once eight bits have been hunted
            if (bit_cnt == 6'd8 && hunt_sr == regs.flag_pattern) begin
                start_field(HEADER);
                crc_acc = regs.crc_init;
            end
        end else begin
            field_sr = {field_sr[30:0], b};
            bit_cnt++;
            done = (phase_q == CRC_FIELD) ? (bit_cnt == 6'd32) : (bit_cnt == 6'd8);
            if (done) begin
                unique case (phase_q)
                    HEADER: begin
                        frame_hdr.control_code   = field_sr[7:4];
                        frame_hdr.payload_length = field_sr[3:0];
                        bytes_to_go              = field_sr[3:0];
                        start_field(RECV_ADDR);
                    end
                    RECV_ADDR: begin
                        frame_hdr.receiver_address = field_sr[7:0];
                        start_field(SEND_ADDR);
                    end
                    SEND_ADDR: begin
                        frame_hdr.sender_address = field_sr[7:0];
                        start_field(SEQ_NUM);
                    end
                    SEQ_NUM: begin
                        frame_hdr.sequence_number = field_sr[7:0];
                        start_field(bytes_to_go != 4'd0 ? PAYLOAD : CRC_FIELD);
                    end
                    PAYLOAD: begin
                        // reflected CRC: fold in the byte LSB first
                        for (k = 0; k < 8; k++) begin
                            fb      = crc_acc[0] ^ field_sr[k];
                            crc_acc = {1'b0, crc_acc[31:1]} ^ (fb ? CRC_POLY : 32'd0);
                        end
                        r.payload_byte = field_sr[7:0];
                        results_due = {results_due, r};
                        bytes_to_go--;
                        start_field(bytes_to_go != 4'd0 ? PAYLOAD : CRC_FIELD);
                    end
                    CRC_FIELD: begin
                        crc_rx = field_sr;
                        start_field(CLOSE_FLAG);
                    end
                    CLOSE_FLAG: begin
                        r.item_kind = KIND_SUMMARY;
                        // a bad closing flag outranks a CRC mismatch
                        if (field_sr[7:0] != regs.flag_pattern)
                            r.frame_status = STATUS_BAD_FLAG;
                        else if ((crc_acc ^ regs.crc_final_xor) != crc_rx)
                            r.frame_status = STATUS_BAD_CRC;
                        results_due = {results_due, r};
                        hunt_sr = 8'd0;
                        start_field(HUNT);
                    end
                    default: ;
                endcase
            end
        end
    endtask

    task automatic check_beat();
        result_t got;
        result_t want;
        got.item_kind        = m_tuser;
        got.payload_byte     = m_tdata[7:0];
        got.frame_status     = m_tdata[9:8];
        got.control_code     = m_tdata[13:10];
        got.payload_length   = m_tdata[17:14];
        got.receiver_address = m_tdata[25:18];
        got.sender_address   = m_tdata[33:26];
        got.sequence_number  = m_tdata[41:34];
        beat_no++;
        if (results_due.size() == 0) begin
            report("beat with nothing expected, item_kind", got.item_kind, 0);
        end else begin
            want = results_due.pop_front();
            if (got.item_kind !== want.item_kind)
                report("item_kind", got.item_kind, want.item_kind);
            if (got.payload_byte !== want.payload_byte)
                report("payload_byte", got.payload_byte, want.payload_byte);
            if (got.frame_status !== want.frame_status)
                report("frame_status", got.frame_status, want.frame_status);
            if (got.control_code !== want.control_code)
                report("control_code", got.control_code, want.control_code);
            if (got.payload_length !== want.payload_length)
                report("payload_length", got.payload_length, want.payload_length);
            if (got.receiver_address !== want.receiver_address)
                report("receiver_address", got.receiver_address, want.receiver_address);
            if (got.sender_address !== want.sender_address)
                report("sender_address", got.sender_address, want.sender_address);
            if (got.sequence_number !== want.sequence_number)
                report("sequence_number", got.sequence_number, want.sequence_number);
            if (want.item_kind == KIND_BYTE) begin
                byte_beats++;
            end else begin
                unique case (want.frame_status)
                    STATUS_GOOD:     good_frames++;
                    STATUS_BAD_FLAG: flag_fails++;
                    default:         crc_fails++;
                endcase
            end
        end
    endtask

    always @(posedge aclk) begin
        if (!aresetn) begin
            regs.flag_pattern  = FLAG_RESET;
            regs.crc_init      = CRC_RESET;
            regs.crc_final_xor = CRC_RESET;
            phase_q            = HUNT;
            hunt_sr            = 8'd0;
            bit_cnt            = 6'd0;
            field_sr           = 32'd0;
            frame_hdr          = '0;
            bytes_to_go        = 4'd0;
            crc_acc            = 32'd0;
            crc_rx             = 32'd0;
            results_due.delete();
            mismatches         = 0;
            beat_no            = 0;
            byte_beats         = 0;
            good_frames        = 0;
            flag_fails         = 0;
            crc_fails          = 0;
        end else begin
            if (psel && penable && pready) begin
                if (pwrite) begin
                    unique case (paddr[3:2])
                        REG_FLAG_PATTERN:  regs.flag_pattern  = pwdata[7:0];
                        REG_CRC_INIT:      regs.crc_init      = pwdata;
                        REG_CRC_FINAL_XOR: regs.crc_final_xor = pwdata;
                        default: ;
                    endcase
                end else begin
                    unique case (paddr[3:2])
                        REG_FLAG_PATTERN:  reg_val = {24'd0, regs.flag_pattern};
                        REG_CRC_INIT:      reg_val = regs.crc_init;
                        REG_CRC_FINAL_XOR: reg_val = regs.crc_final_xor;
                        default:           reg_val = prdata;
                    endcase
                    if (prdata !== reg_val) report("register readback", prdata, reg_val);
                end
            end
            if (s_tvalid && s_tready) deframe_bit(s_tdata[0]);
            if (m_tvalid && m_tready) check_beat();
        end
        pending <= results_due.size();
    end

endmodule

/* tb/flag_framed_packet_receiver_test.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// flag_framed_packet_receiver_test
// Drives framed bit streams into the flag-framed receiver: directed frames for
// the header extremes, empty frames and each failure kind, then random frames
// with noise and truncated frames, under several register settings and random
// back-pressure. The checker beside the block predicts and compares.
// ----------------------------------------------------------------------------
module flag_framed_packet_receiver_test;
    import ffpr_pkg::*;

    localparam int CYCLE_LIMIT  = 400000;
    localparam int LONG_HOLD    = 300;
    localparam int DRAIN_CYCLES = 16;
    localparam int PHASE_BITS   = 180;
    localparam logic [1:0] REG_SPARE = 2'd3;   // unmapped index, writes are dropped

    logic                aclk     = 1'b0;
    logic                aresetn  = 1'b0;
    logic                s_tvalid = 1'b0;
    logic                s_tready;
    logic [7:0]          s_tdata  = 8'd0;
    logic                m_tvalid;
    logic                m_tready = 1'b0;
    logic [47:0]         m_tdata;
    logic                m_tuser;
    logic                psel     = 1'b0;
    logic                penable  = 1'b0;
    logic                pwrite   = 1'b0;
    logic [CfgAddrW-1:0] paddr    = '0;
    logic [31:0]         pwdata   = 32'd0;
    logic [31:0]         prdata;
    logic                pready;

    int mismatches, pending, byte_beats, good_frames, flag_fails, crc_fails;
    int bits_sent, frames_sent, settings_used, cycle_count, phase_end;
    int hold_asks, holds_done, stall_left;
    bit send_idle_on, sink_idle_on;

    logic [7:0]  cur_flag = FLAG_RESET;
    logic [31:0] cur_init = CRC_RESET;
    logic [31:0] cur_xor  = CRC_RESET;

    flag_framed_packet_receiver DUT (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready)
    );

    flag_framed_packet_receiver_check checker_i (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready),
        .mismatches(mismatches), .pending(pending), .byte_beats(byte_beats),
        .good_frames(good_frames), .flag_fails(flag_fails), .crc_fails(crc_fails)
    );

    initial begin
        forever #5 aclk = ~aclk;
    end

    // mostly no gap, some short ones, now and then a long one
    function automatic int pick_gap(input bit on);
        int r;
        r = $urandom_range(0, 99);
        if (!on || r < 60) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    function automatic logic [7:0] rand_octet();
        int r;
        r = $urandom_range(0, 9);
        if (r < 2) return 8'h00;
        if (r < 4) return 8'hFF;
        return 8'($urandom_range(0, 255));
    endfunction

    task automatic send_bit(input logic b);
        int gap;
        gap = pick_gap(send_idle_on);
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {7'd0, b};
        do @(posedge aclk); while (!s_tready);
        bits_sent++;
    endtask

    task automatic send_bits(input logic [31:0] value, input int n);
        int i;
        for (i = n - 1; i >= 0; i--) send_bit(value[i]);
    endtask

    task automatic send_frame(input logic [3:0] ctl, input logic [3:0] len,
                              input logic [7:0] rx, input logic [7:0] tx,
                              input logic [7:0] seq, input logic bad_crc,
                              input logic bad_close);
        logic [31:0] crc;
        logic [7:0]  octet;
        logic [7:0]  close;
        int          i;
        crc = cur_init;
        send_bits({24'd0, cur_flag}, 8);
        send_bits({24'd0, ctl, len}, 8);
        send_bits({24'd0, rx}, 8);
        send_bits({24'd0, tx}, 8);
        send_bits({24'd0, seq}, 8);
        for (i = 0; i < len; i++) begin
            octet = rand_octet();
            crc   = crc ^ {24'd0, octet};
            repeat (8) crc = crc[0] ? ((crc >> 1) ^ CRC_POLY) : (crc >> 1);
            send_bits({24'd0, octet}, 8);
        end
        crc = crc ^ cur_xor;
        if (bad_crc) crc = crc ^ (32'd1 << $urandom_range(0, 31));
        send_bits(crc, 32);
        close = cur_flag;
        if (bad_close) begin
            do close = 8'($urandom_range(0, 255)); while (close == cur_flag);
        end
        send_bits({24'd0, close}, 8);
        frames_sent++;
    endtask

    task automatic random_frame();
        int         pick;
        logic [3:0] len;
        pick = $urandom_range(0, 99);
        if (pick < 50)      len = 4'($urandom_range(0, 2));
        else if (pick < 85) len = 4'($urandom_range(3, 7));
        else                len = 4'($urandom_range(8, 15));
        pick = $urandom_range(0, 99);
        if (pick < 10) begin
            // truncated frame: flag, then a short stretch that runs into the next one
            send_bits({24'd0, cur_flag}, 8);
            send_bits($urandom, $urandom_range(1, 32));
        end else if (pick < 30) begin
            send_bits($urandom, $urandom_range(1, 12));
        end
        pick = $urandom_range(0, 99);
        send_frame(4'($urandom_range(0, 15)), len, rand_octet(), rand_octet(), rand_octet(),
                   (pick >= 70 && pick < 82) || pick >= 94, pick >= 82);
    endtask

    // hold the line until every expected result is out, then let the block settle
    task automatic drain();
        s_tvalid <= 1'b0;
        do @(posedge aclk); while (pending != 0);
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    task automatic apb_access(input logic wr, input logic [1:0] idx, input logic [31:0] data);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= wr;
        paddr   <= {idx, 2'b00};
        pwdata  <= data;
        @(posedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge aclk);
    endtask

    task automatic read_back();
        apb_access(1'b0, REG_FLAG_PATTERN, 32'd0);
        apb_access(1'b0, REG_CRC_INIT, 32'd0);
        apb_access(1'b0, REG_CRC_FINAL_XOR, 32'd0);
    endtask

    task automatic set_config(input logic [7:0] flag, input logic [31:0] init,
                              input logic [31:0] fxor);
        drain();
        apb_access(1'b1, REG_FLAG_PATTERN, {24'd0, flag});
        apb_access(1'b1, REG_CRC_INIT, init);
        apb_access(1'b1, REG_CRC_FINAL_XOR, fxor);
        apb_access(1'b1, REG_SPARE, $urandom);
        read_back();
        cur_flag = flag;
        cur_init = init;
        cur_xor  = fxor;
        settings_used++;
    endtask

    task automatic random_phase();
        phase_end = bits_sent + PHASE_BITS;
        while (bits_sent < phase_end) random_frame();
    endtask

    // result side: random stalls, plus the long hold when asked for
    initial begin
        forever begin
            @(posedge aclk);
            if (hold_asks != holds_done) begin
                holds_done++;
                stall_left = LONG_HOLD;
            end
            if (stall_left > 0) begin
                m_tready <= 1'b0;
                stall_left--;
            end else begin
                m_tready <= 1'b1;
                stall_left = pick_gap(sink_idle_on);
            end
        end
    end

    initial begin
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge aclk);
            cycle_count++;
        end
        $display("flag_framed_packet_receiver_test: done, errors");
        $finish;
    end

    initial begin
        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        read_back();
        settings_used = 1;

        // directed frames at reset settings, no idling on either side
        send_idle_on = 1'b0;
        sink_idle_on = 1'b0;
        send_frame(4'h0, 4'h0, 8'h00, 8'h00, 8'h00, 1'b0, 1'b0);
        send_frame(4'hF, 4'h1, 8'hFF, 8'hFF, 8'hFF, 1'b0, 1'b0);
        send_frame(4'hA, 4'h2, 8'h5A, 8'hA5, 8'h01, 1'b1, 1'b0);
        send_frame(4'h3, 4'h1, 8'h12, 8'h34, 8'h56, 1'b0, 1'b1);
        send_frame(4'hC, 4'h0, 8'h80, 8'h01, 8'h7E, 1'b1, 1'b1);

        // all-zero flag: seven zeros then a one must not open a frame
        set_config(8'h00, 32'h0000_0000, 32'h0000_0000);
        send_idle_on = 1'b1;
        sink_idle_on = 1'b1;
        send_bits(32'h01, 8);
        send_frame(4'hF, 4'hF, 8'hFF, 8'h00, 8'hFF, 1'b0, 1'b0);
        random_phase();

        // fill the result register and stall the line for a long stretch
        set_config(8'hFF, 32'hFFFF_FFFF, 32'h0000_0000);
        send_idle_on = 1'b0;
        hold_asks++;
        random_phase();

        set_config(8'($urandom_range(0, 255)), $urandom, $urandom);
        send_idle_on = 1'b0;
        random_phase();

        set_config(FLAG_RESET, $urandom, CRC_RESET);
        send_idle_on = 1'b1;
        sink_idle_on = 1'b0;
        random_phase();

        drain();
        $display("Covered %0d line bits, %0d frames sent, %0d register settings, one long hold.",
                 bits_sent, frames_sent, settings_used);
        $display("Checked %0d payload bytes; frames: %0d good, %0d bad flag, %0d bad CRC.",
                 byte_beats, good_frames, flag_fails, crc_fails);
        if (mismatches == 0) begin
            $display("flag_framed_packet_receiver_test: done, clean");
        end else begin
            $display("flag_framed_packet_receiver_test: done, errors");
        end
        $finish;
    end

endmodule
